// File: sv/rft_pkg.sv
// ----------------------------------------------------------------------------
// rft_pkg: shared definitions for the route flow table
// Table geometry, field widths, operation codes, register selects and the
// structs passed between the sequencer, the entry store and the top level.
// ----------------------------------------------------------------------------
package rft_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int ADDR_W  = 16;
  localparam int ACT_W   = 4;
  localparam int AGE_W   = 8;
  localparam int OP_W    = 3;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(TABLE_DEPTH);
  localparam logic [AGE_W-1:0] AGE_MAX   = {AGE_W{1'b1}};

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_HOP = 3'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
  localparam logic [OP_W-1:0] OP_INIT       = 3'd5;

  // Register selects, taken from paddr[2].
  localparam logic REG_OWN_ADDRESS    = 1'b0;
  localparam logic REG_RECEIVE_ACTION = 1'b1;

  // Routing payload of one table entry.
  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] hop;
    logic [ACT_W-1:0]  action;
  } route_t;

  // Write command from the sequencer to the entry store.
  typedef struct packed {
    logic             clr_all;
    logic             set_en;
    logic             inval_en;
    logic             age_en;
    logic [IDX_W-1:0] wr_idx;
    route_t           wr_route;
    logic [AGE_W-1:0] wr_age;
  } store_cmd_t;

  // One result item.
  typedef struct packed {
    logic              status;
    logic              hit;
    logic [ADDR_W-1:0] found_next_hop;
    logic [ACT_W-1:0]  found_action;
    logic [AGE_W-1:0]  found_age;
  } result_t;

endpackage

// File: sv/rft_entry_store.sv
// ----------------------------------------------------------------------------
// rft_entry_store: table entry storage
// Valid bits in flip-flops cleared by reset, route and age memories with one
// write port each and a registered read port shared by all passes.
// ----------------------------------------------------------------------------
module rft_entry_store (
  input  logic                            clk,
  input  logic                            rst,
  input  rft_pkg::store_cmd_t             cmd,
  input  logic [rft_pkg::IDX_W-1:0]       rd_idx,
  output logic                            rd_valid,
  output rft_pkg::route_t                 rd_route,
  output logic [rft_pkg::AGE_W-1:0]       rd_age
);
  import rft_pkg::*;

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] valid_next;
  route_t                 route_mem [TABLE_DEPTH];
  logic [AGE_W-1:0]       age_mem   [TABLE_DEPTH];

  // Valid bits: a full clear may be combined with setting one entry.
  always_comb begin
    valid_next = valid;
    if (cmd.clr_all) begin
      valid_next = '0;
    end
    if (cmd.set_en) begin
      valid_next[cmd.wr_idx] = 1'b1;
    end
    if (cmd.inval_en) begin
      valid_next[cmd.wr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  // Route memory is written only when an entry is set.
  always_ff @(posedge clk) begin
    if (cmd.set_en) begin
      route_mem[cmd.wr_idx] <= cmd.wr_route;
    end
  end

  // Age memory is written on set and on each aging step.
  always_ff @(posedge clk) begin
    if (cmd.set_en || cmd.age_en) begin
      age_mem[cmd.wr_idx] <= cmd.wr_age;
    end
  end

  // Registered read of the entry the sequencer points at.
  always_ff @(posedge clk) begin
    rd_route <= route_mem[rd_idx];
    rd_age   <= age_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_idx];
    end
  end

endmodule

// File: sv/rft_seq.sv
// ----------------------------------------------------------------------------
// rft_seq: operation sequencer with a shared compare and age unit
// Walks the entry store one entry per cycle, compares the key against each
// entry, issues writes and invalidations, and runs the aging pass after an insert that finds a slot.
// ----------------------------------------------------------------------------
module rft_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_go,
  input  logic [rft_pkg::OP_W-1:0]        operation,
  input  logic [rft_pkg::ADDR_W-1:0]      destination,
  input  logic [rft_pkg::ADDR_W-1:0]      hop_address,
  input  logic [rft_pkg::ACT_W-1:0]       action,
  input  logic [rft_pkg::ADDR_W-1:0]      own_address,
  input  logic [rft_pkg::ACT_W-1:0]       receive_action,
  input  logic                            res_free,
  input  logic                            rd_valid,
  input  rft_pkg::route_t                 rd_route,
  input  logic [rft_pkg::AGE_W-1:0]       rd_age,
  output logic                            busy,
  output logic                            res_load,
  output rft_pkg::result_t                result,
  output rft_pkg::store_cmd_t             cmd,
  output logic [rft_pkg::IDX_W-1:0]       rd_idx
);
  import rft_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_AGE   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [OP_W-1:0]  op, op_next;
  route_t           key, key_next;
  logic             match_found, match_found_next;
  logic [IDX_W-1:0] match_idx, match_idx_next;
  logic             free_found, free_found_next;
  logic [IDX_W-1:0] free_idx, free_idx_next;
  result_t          res, res_next;

  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] p_idx;
  logic             have_data;
  logic             last;
  logic             dest_match;
  logic             hop_match;

  // The read for entry cnt is issued now; the data for entry cnt-1 arrives now.
  assign cnt_m1     = cnt - 1'b1;
  assign p_idx      = cnt_m1[IDX_W-1:0];
  assign have_data  = (cnt != '0);
  assign last       = (cnt == SCAN_LAST);
  assign rd_idx     = last ? '0 : cnt[IDX_W-1:0];
  assign dest_match = rd_valid && (rd_route.dest == key.dest);
  assign hop_match  = rd_valid && (rd_route.hop == key.hop);
  assign busy       = (state != ST_IDLE);
  assign result     = res;

  // Next-state and command logic.
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    op_next          = op;
    key_next         = key;
    match_found_next = match_found;
    match_idx_next   = match_idx;
    free_found_next  = free_found;
    free_idx_next    = free_idx;
    res_next         = res;
    cmd              = '0;
    res_load         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_go) begin
          op_next          = operation;
          key_next.dest    = destination;
          key_next.hop     = hop_address;
          key_next.action  = action;
          cnt_next         = '0;
          match_found_next = 1'b0;
          free_found_next  = 1'b0;
          res_next         = '0;
          unique case (operation)
            OP_INSERT, OP_REMOVE, OP_REMOVE_HOP, OP_LOOKUP: begin
              state_next = ST_SCAN;
            end
            OP_CLEAR: begin
              cmd.clr_all = 1'b1;
              state_next  = ST_DONE;
            end
            OP_INIT: begin
              // After the clear only slot zero is valid, so its age reads one.
              cmd.clr_all         = 1'b1;
              cmd.set_en          = 1'b1;
              cmd.wr_idx          = '0;
              cmd.wr_route.dest   = own_address;
              cmd.wr_route.hop    = own_address;
              cmd.wr_route.action = receive_action;
              cmd.wr_age          = AGE_W'(1);
              state_next          = ST_DONE;
            end
            default: begin
              res_next.status = 1'b1;
              state_next      = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        cnt_next = cnt + 1'b1;
        if (have_data) begin
          unique case (op)
            OP_INSERT: begin
              if (dest_match) begin
                match_found_next = 1'b1;
                match_idx_next   = p_idx;
              end
              if (!rd_valid && !free_found) begin
                free_found_next = 1'b1;
                free_idx_next   = p_idx;
              end
            end
            OP_REMOVE: begin
              if (dest_match) begin
                cmd.inval_en     = 1'b1;
                cmd.wr_idx       = p_idx;
                match_found_next = 1'b1;
              end
            end
            OP_REMOVE_HOP: begin
              if (hop_match) begin
                cmd.inval_en = 1'b1;
                cmd.wr_idx   = p_idx;
              end
            end
            OP_LOOKUP: begin
              if (dest_match) begin
                match_found_next        = 1'b1;
                res_next.hit            = 1'b1;
                res_next.found_next_hop = rd_route.hop;
                res_next.found_action   = rd_route.action;
                res_next.found_age      = rd_age;
              end
            end
            default: begin
            end
          endcase
        end
        if (last) begin
          if (op == OP_INSERT) begin
            state_next = ST_WRITE;
          end else begin
            if (op == OP_REMOVE || op == OP_LOOKUP) begin
              res_next.status = !match_found_next;
            end
            state_next = ST_DONE;
          end
        end
      end

      ST_WRITE: begin
        if (!match_found && !free_found) begin
          // Table full: nothing changes, ages included.
          res_next.status = 1'b1;
          state_next      = ST_DONE;
        end else begin
          cmd.set_en          = 1'b1;
          cmd.wr_idx          = match_found ? match_idx : free_idx;
          cmd.wr_route.dest   = key.dest;
          cmd.wr_route.hop    = key.hop;
          cmd.wr_route.action = (key.hop == own_address) ? receive_action : key.action;
          cmd.wr_age          = '0;
          cnt_next            = '0;
          state_next          = ST_AGE;
        end
      end

      ST_AGE: begin
        // Saturating increment of every valid entry's age.
        cnt_next = cnt + 1'b1;
        if (have_data && rd_valid && (rd_age != AGE_MAX)) begin
          cmd.age_en = 1'b1;
          cmd.wr_idx = p_idx;
          cmd.wr_age = rd_age + 1'b1;
        end
        if (last) begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      match_found <= match_found_next;
      free_found  <= free_found_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op        <= op_next;
    key       <= key_next;
    match_idx <= match_idx_next;
    free_idx  <= free_idx_next;
    res       <= res_next;
  end

endmodule

// File: sv/route_flow_table.sv
// ----------------------------------------------------------------------------
// route_flow_table: exact-match routing table with aging
// Sixteen-entry routing table with insert, remove, remove by next hop,
// lookup, clear and init, configured through an APB-style register port.
//
//   Channel   Handshake            Payload
//   input     in_valid / in_stall  operation, destination, hop_address, action
//   output    out_valid/out_stall  status, hit, found_next_hop, found_action,
//                                  found_age
//   config    psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One operation at a time; in_stall is high from the transfer until the
// result is loaded into the output register. Insert scans the table and, if
// it finds a slot, writes the entry and then ages the table; remove, remove
// by next hop and lookup scan it once; clear, init and unknown codes go
// straight to the final step. The single compare unit walks the entry memory
// one registered read per cycle, twice on an insert that finds a slot.
// Reset is synchronous and empties the table at once through the valid bits.
// A result waiting on out_stall holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module route_flow_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rft_pkg::OP_W-1:0]      operation,
  input  logic [rft_pkg::ADDR_W-1:0]    destination,
  input  logic [rft_pkg::ADDR_W-1:0]    hop_address,
  input  logic [rft_pkg::ACT_W-1:0]     action,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic                          hit,
  output logic [rft_pkg::ADDR_W-1:0]    found_next_hop,
  output logic [rft_pkg::ACT_W-1:0]     found_action,
  output logic [rft_pkg::AGE_W-1:0]     found_age,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rft_pkg::PADDR_W-1:0]   paddr,
  input  logic [rft_pkg::PDATA_W-1:0]   pwdata,
  output logic [rft_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import rft_pkg::*;

  logic [ADDR_W-1:0] own_address;
  logic [ACT_W-1:0]  receive_action;
  logic              cfg_we;
  logic              busy;
  logic              in_go;
  logic              res_free;
  logic              res_load;
  result_t           seq_result;
  result_t           out_res;
  store_cmd_t        cmd;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_valid;
  route_t            rd_route;
  logic [AGE_W-1:0]  rd_age;

  // Configuration registers, selected by paddr[2].
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address    <= '0;
      receive_action <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_OWN_ADDRESS:    own_address    <= pwdata[ADDR_W-1:0];
        REG_RECEIVE_ACTION: receive_action <= pwdata[ACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OWN_ADDRESS:    prdata = PDATA_W'(own_address);
      REG_RECEIVE_ACTION: prdata = PDATA_W'(receive_action);
      default:            prdata = '0;
    endcase
  end

  // Input transfer.
  assign in_stall = busy;
  assign in_go    = in_valid && !in_stall;

  // Output register: free when empty or being taken this cycle.
  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= seq_result;
    end
  end

  assign status         = out_res.status;
  assign hit            = out_res.hit;
  assign found_next_hop = out_res.found_next_hop;
  assign found_action   = out_res.found_action;
  assign found_age      = out_res.found_age;

  rft_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_go          (in_go),
    .operation      (operation),
    .destination    (destination),
    .hop_address    (hop_address),
    .action         (action),
    .own_address    (own_address),
    .receive_action (receive_action),
    .res_free       (res_free),
    .rd_valid       (rd_valid),
    .rd_route       (rd_route),
    .rd_age         (rd_age),
    .busy           (busy),
    .res_load       (res_load),
    .result         (seq_result),
    .cmd            (cmd),
    .rd_idx         (rd_idx)
  );

  rft_entry_store u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_idx   (rd_idx),
    .rd_valid (rd_valid),
    .rd_route (rd_route),
    .rd_age   (rd_age)
  );

endmodule

// File: sv/rft_checker.sv
// ----------------------------------------------------------------------------
// rft_checker: port-level checks for the route flow table
// Watches the top-level ports and flags results or handshakes that the
// table can never produce; bound to every route_flow_table instance.
// ----------------------------------------------------------------------------
module rft_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          status,
  input logic                          hit,
  input logic [rft_pkg::ADDR_W-1:0]    found_next_hop,
  input logic [rft_pkg::ACT_W-1:0]     found_action,
  input logic [rft_pkg::AGE_W-1:0]     found_age,
  input logic                          pready
);
  import rft_pkg::*;

  // A lookup hit always reports success.
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !status)
    else $error("hit reported together with error status");

  // Found fields are zero unless the result is a lookup hit.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (found_next_hop == '0) && (found_action == '0) &&
                          (found_age == '0))
    else $error("found fields nonzero without a hit");

  // Every stored entry has been aged at least once.
  a_age_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> found_age != '0)
    else $error("hit with zero age");

  // An accepted item keeps the input stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(hit) &&
                               $stable(found_age) && pready)
    else $error("stalled result changed");

endmodule

bind route_flow_table rft_checker u_rft_checker (.*);

// File: tb/sv/route_flow_table_tb.sv
// ----------------------------------------------------------------------------
// route_flow_table_tb: self-checking testbench for the route flow table
// Drives table operations through the valid/stall input channel, and
// configuration through the register port. A behavioral copy of the table
// predicts every result, and each result transfer is compared field by field
// with the oldest prediction. Directed tests cover the field extremes, each
// operation, a full table and age saturation. A back-pressure test follows,
// and a randomized traffic test then runs several register settings.
// ----------------------------------------------------------------------------
module route_flow_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rft_pkg::*;

  // Operation codes that the block does not define.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // Byte addresses of the two registers.
  localparam logic [PADDR_W-1:0] ADDR_OWN_ADDRESS    = {REG_OWN_ADDRESS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_RECEIVE_ACTION = {REG_RECEIVE_ACTION, 2'b00};

  localparam int CYCLE_LIMIT = 500_000;
  localparam int MAX_IDLE    = 17;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    operation;
  logic [ADDR_W-1:0]  destination;
  logic [ADDR_W-1:0]  hop_address;
  logic [ACT_W-1:0]   action;
  logic               out_valid;
  logic               out_stall;
  logic               status;
  logic               hit;
  logic [ADDR_W-1:0]  found_next_hop;
  logic [ACT_W-1:0]   found_action;
  logic [AGE_W-1:0]   found_age;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Shadow copy of the routing table and its registers.
  logic               route_valid  [TABLE_DEPTH];
  logic [ADDR_W-1:0]  route_dest   [TABLE_DEPTH];
  logic [ADDR_W-1:0]  route_hop    [TABLE_DEPTH];
  logic [ACT_W-1:0]   route_action [TABLE_DEPTH];
  logic [AGE_W-1:0]   route_age    [TABLE_DEPTH];
  logic [ADDR_W-1:0]  model_own_address;
  logic [ACT_W-1:0]   model_receive_action;
  result_t            expected_results [$];

  // Idle controls shared by the sender, the receiver and the tests.
  logic               sender_idle;
  logic               sink_idle;
  int unsigned        sink_hold;
  int unsigned        failure_count = 0;
  int unsigned        cycle_count = 0;

  route_flow_table DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .destination    (destination),
    .hop_address    (hop_address),
    .action         (action),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .hit            (hit),
    .found_next_hop (found_next_hop),
    .found_action   (found_action),
    .found_age      (found_age),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Free-running 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Only the first ten failures are printed; the rest are counted.
  function automatic void note_failure(input string msg);
    failure_count++;
    if (failure_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  // Slot holding a valid entry for this destination, or -1.
  function automatic int find_route(input logic [ADDR_W-1:0] dest);
    int slot;
    slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot < 0 && route_valid[i] && route_dest[i] == dest) slot = i;
    end
    return slot;
  endfunction

  function automatic void clear_routes();
    for (int i = 0; i < TABLE_DEPTH; i++) route_valid[i] = 1'b0;
  endfunction

  // Update a matching entry or take the lowest free slot, then age the table.
  function automatic logic insert_route(input logic [ADDR_W-1:0] dest, hop,
                                        input logic [ACT_W-1:0] act);
    int slot;
    slot = find_route(dest);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot < 0 && !route_valid[i]) slot = i;
    end
    if (slot < 0) return 1'b1;
    route_valid[slot]  = 1'b1;
    route_dest[slot]   = dest;
    route_hop[slot]    = hop;
    route_action[slot] = (hop == model_own_address) ? model_receive_action : act;
    route_age[slot]    = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (route_valid[i] && route_age[i] != AGE_MAX) route_age[i] = route_age[i] + 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one operation to the shadow table and return the result it gives.
  function automatic result_t predict_route_op(input logic [OP_W-1:0] op,
                                               input logic [ADDR_W-1:0] dest, hop,
                                               input logic [ACT_W-1:0] act);
    result_t res;
    int      slot;
    res = '0;
    case (op)
      OP_INSERT: begin
        res.status = insert_route(dest, hop, act);
      end
      OP_REMOVE: begin
        slot = find_route(dest);
        if (slot < 0) res.status = 1'b1;
        else route_valid[slot] = 1'b0;
      end
      OP_REMOVE_HOP: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (route_valid[i] && route_hop[i] == hop) route_valid[i] = 1'b0;
        end
      end
      OP_LOOKUP: begin
        slot = find_route(dest);
        if (slot < 0) begin
          res.status = 1'b1;
        end else begin
          res.hit            = 1'b1;
          res.found_next_hop = route_hop[slot];
          res.found_action   = route_action[slot];
          res.found_age      = route_age[slot];
        end
      end
      OP_CLEAR: begin
        clear_routes();
      end
      OP_INIT: begin
        clear_routes();
        res.status = insert_route(model_own_address, model_own_address, model_receive_action);
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    return res;
  endfunction

  // Offer one operation and record its prediction once the transfer happens.
  // Entered and left just after a falling edge.
  task automatic send_route_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] dest, hop,
                               input logic [ACT_W-1:0] act);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    destination <= dest;
    hop_address <= hop;
    action      <= act;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_route_op(op, dest, hop, act));
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0 || in_stall);
  endtask

  // Register write followed by a read back of the same register.
  task automatic set_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] written;
    logic [PDATA_W-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_OWN_ADDRESS) begin
      model_own_address = value[ADDR_W-1:0];
      written = {{(PDATA_W-ADDR_W){1'b0}}, value[ADDR_W-1:0]};
    end else begin
      model_receive_action = value[ACT_W-1:0];
      written = {{(PDATA_W-ACT_W){1'b0}}, value[ACT_W-1:0]};
    end
    @(negedge clk);
    psel <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== written) begin
      note_failure($sformatf("register at %0d reads %0h, expected %0h", addr, readback, written));
    end
  endtask

  // Every operation at the field extremes, forced receive and unknown codes.
  task automatic test_directed_ops();
    set_register(ADDR_OWN_ADDRESS, 32'h0000_1234);
    set_register(ADDR_RECEIVE_ACTION, 32'h0000_0009);
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    // Misses on an empty table; remove by next hop still succeeds.
    send_route_op(OP_LOOKUP, 16'h1234, 16'h0000, 4'h0);
    send_route_op(OP_REMOVE, 16'h0000, 16'h0000, 4'h0);
    send_route_op(OP_REMOVE_HOP, 16'h0000, 16'hFFFF, 4'h0);
    // Init ignores its fields and installs the own-address entry.
    send_route_op(OP_INIT, 16'hFFFF, 16'hFFFF, 4'hF);
    send_route_op(OP_LOOKUP, 16'h1234, 16'h0000, 4'h0);
    send_route_op(OP_INSERT, 16'h0000, 16'hFFFF, 4'h0);
    send_route_op(OP_INSERT, 16'hFFFF, 16'h0000, 4'hF);
    // Next hop equal to the own address forces the receive action.
    send_route_op(OP_INSERT, 16'h0042, 16'h1234, 4'h3);
    send_route_op(OP_LOOKUP, 16'h0042, 16'hFFFF, 4'hF);
    send_route_op(OP_LOOKUP, 16'h0000, 16'h0000, 4'h0);
    send_route_op(OP_LOOKUP, 16'hFFFF, 16'h0000, 4'h0);
    // Updating an existing destination restarts its age.
    send_route_op(OP_INSERT, 16'h0000, 16'h0007, 4'h5);
    send_route_op(OP_LOOKUP, 16'h0000, 16'h0000, 4'h0);
    send_route_op(OP_SPARE_6, 16'hFFFF, 16'hFFFF, 4'hF);
    send_route_op(OP_SPARE_7, 16'h0000, 16'h0000, 4'h0);
    send_route_op(OP_REMOVE, 16'hFFFF, 16'h0000, 4'h0);
    send_route_op(OP_LOOKUP, 16'hFFFF, 16'h0000, 4'h0);
    // Remove by next hop drops every entry that uses it.
    send_route_op(OP_INSERT, 16'h0100, 16'h0007, 4'hA);
    send_route_op(OP_REMOVE_HOP, 16'hFFFF, 16'h0007, 4'hF);
    send_route_op(OP_LOOKUP, 16'h0100, 16'h0000, 4'h0);
    send_route_op(OP_LOOKUP, 16'h0000, 16'h0000, 4'h0);
    send_route_op(OP_CLEAR, 16'hFFFF, 16'hFFFF, 4'hF);
    send_route_op(OP_LOOKUP, 16'h1234, 16'h0000, 4'h0);
    wait_for_drain();
  endtask

  // A full table rejects new destinations but still accepts updates.
  task automatic test_table_full();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    send_route_op(OP_CLEAR, 16'h0000, 16'h0000, 4'h0);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_route_op(OP_INSERT, 16'h8000 + 16'(i), ADDR_W'($urandom_range(0, 16'hFFFF)),
                    ACT_W'($urandom_range(0, 15)));
    end
    send_route_op(OP_INSERT, 16'h7FFF, 16'h0001, 4'h2);
    send_route_op(OP_INSERT, 16'h8000, 16'h0002, 4'h6);
    send_route_op(OP_LOOKUP, 16'h7FFF, 16'h0000, 4'h0);
    send_route_op(OP_REMOVE, 16'h8003, 16'h0000, 4'h0);
    send_route_op(OP_INSERT, 16'h7FFF, 16'h0001, 4'h2);
    send_route_op(OP_LOOKUP, 16'h7FFF, 16'h0000, 4'h0);
    send_route_op(OP_LOOKUP, 16'h8000, 16'h0000, 4'h0);
    wait_for_drain();
  endtask

  // An entry left alone while others are written ages up to saturation.
  task automatic test_age_saturation();
    sender_idle = 1'b0;
    sink_idle   = 1'b1;
    send_route_op(OP_CLEAR, 16'h0000, 16'h0000, 4'h0);
    send_route_op(OP_INSERT, 16'h0A0A, 16'h0505, 4'h1);
    repeat (260) begin
      send_route_op(OP_INSERT, 16'h0B0B, ADDR_W'($urandom_range(0, 16'hFFFF)),
                    ACT_W'($urandom_range(0, 15)));
    end
    send_route_op(OP_LOOKUP, 16'h0A0A, 16'h0000, 4'h0);
    send_route_op(OP_LOOKUP, 16'h0B0B, 16'h0000, 4'h0);
    wait_for_drain();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    sink_hold   = 300;
    repeat (12) begin
      send_route_op(($urandom_range(0, 1) != 0) ? OP_INSERT : OP_LOOKUP,
                    ADDR_W'($urandom_range(0, 7)), ADDR_W'($urandom_range(0, 16'hFFFF)),
                    ACT_W'($urandom_range(0, 15)));
    end
    wait_for_drain();
  endtask

  // Random traffic over small address pools under several register settings.
  task automatic test_random_traffic();
    logic [ADDR_W-1:0] dest_pool [24];
    logic [ADDR_W-1:0] hop_pool  [6];
    logic [ADDR_W-1:0] own;
    logic [ACT_W-1:0]  recv;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] hop;
    logic [ACT_W-1:0]  act;
    int unsigned       pick;
    for (int phase = 0; phase < 6; phase++) begin
      // Register extremes first, then random settings.
      case (phase)
        0: begin own = '0; recv = '0; end
        1: begin own = '1; recv = '1; end
        default: begin
          own  = ADDR_W'($urandom_range(0, 16'hFFFF));
          recv = ACT_W'($urandom_range(0, 15));
        end
      endcase
      wait_for_drain();
      set_register(ADDR_OWN_ADDRESS, {16'h0000, own});
      set_register(ADDR_RECEIVE_ACTION, {28'h0, recv});
      sender_idle = (phase % 3) != 2;
      sink_idle   = (phase % 3) != 1;
      // More destinations than slots, so the table fills now and then.
      foreach (dest_pool[i]) dest_pool[i] = ADDR_W'($urandom_range(0, 16'hFFFF));
      foreach (hop_pool[i]) hop_pool[i] = ADDR_W'($urandom_range(0, 16'hFFFF));
      dest_pool[0] = own;
      hop_pool[0]  = own;
      repeat (155) begin
        pick = $urandom_range(0, 199);
        dest = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom_range(0, 16'hFFFF))
                                           : dest_pool[$urandom_range(0, 23)];
        hop  = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom_range(0, 16'hFFFF))
                                           : hop_pool[$urandom_range(0, 5)];
        act  = ACT_W'($urandom_range(0, 15));
        if (pick < 90) op = OP_INSERT;
        else if (pick < 140) op = OP_LOOKUP;
        else if (pick < 165) op = OP_REMOVE;
        else if (pick < 178) op = OP_REMOVE_HOP;
        else if (pick < 181) op = OP_CLEAR;
        else if (pick < 184) op = OP_INIT;
        else begin
          // Noise: any code, any addresses.
          op   = OP_W'($urandom_range(0, 7));
          dest = ADDR_W'($urandom_range(0, 16'hFFFF));
          hop  = ADDR_W'($urandom_range(0, 16'hFFFF));
        end
        send_route_op(op, dest, hop, act);
      end
    end
    wait_for_drain();
  endtask

  // Receiver: stalls a waiting result at random, or once for sink_hold.
  initial begin : result_sink
    int unsigned pause;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (out_valid) begin
        if (sink_hold > 0) begin
          pause     = sink_hold;
          sink_hold = 0;
        end else begin
          pause = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
        end
        if (pause > 0) begin
          out_stall <= 1'b1;
          repeat (pause) @(negedge clk);
          out_stall <= 1'b0;
        end
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_failure("result transfer with no operation outstanding");
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          note_failure($sformatf("status: expected %0b, got %0b", want.status, status));
        if (hit !== want.hit)
          note_failure($sformatf("hit: expected %0b, got %0b", want.hit, hit));
        if (found_next_hop !== want.found_next_hop)
          note_failure($sformatf("found_next_hop: expected %h, got %h",
                                 want.found_next_hop, found_next_hop));
        if (found_action !== want.found_action)
          note_failure($sformatf("found_action: expected %h, got %h",
                                 want.found_action, found_action));
        if (found_age !== want.found_age)
          note_failure($sformatf("found_age: expected %0d, got %0d", want.found_age, found_age));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: cycle limit reached with %0d results outstanding",
               expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = OP_INSERT;
    destination = '0;
    hop_address = '0;
    action      = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    sink_hold   = 0;
    clear_routes();
    model_own_address    = '0;
    model_receive_action = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_table_full();
    test_age_saturation();
    test_backpressure();
    test_random_traffic();

    // Let any late or spurious result show up before the verdict.
    wait_for_drain();
    repeat (40) @(posedge clk);
    if (failure_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
